// ===== design/feedback_echo_with_fade_in_core_macros.svh =====
// Assertion macros shared by the feedback echo RTL.
// Expects signals named clock and reset in the including module.
`ifndef FEEDBACK_ECHO_WITH_FADE_IN_CORE_MACROS_SVH
`define FEEDBACK_ECHO_WITH_FADE_IN_CORE_MACROS_SVH

// same-cycle implication
`define FBECHO_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FBECHO_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fbecho_pkg.sv =====
// Shared types, constants and fixed-point helpers for the feedback echo core.
// No dependencies.
`default_nettype none

package fbecho_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int DL_W       = 17;
   localparam int FL_W       = 20;
   localparam int MEM_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int OPA_W      = 25;
   localparam int OPB_W      = 21;
   localparam int PROD_W     = OPA_W + OPB_W;
   localparam int QUO_W      = 16;
   localparam int DIVD_W     = QUO_W + FL_W;
   localparam int Q_FRAC     = 14;

   localparam int DEF_DELAY_DEPTH = 65536;

   localparam logic [DL_W-1:0]   RST_DELAY_LENGTH  = DL_W'(48000);
   localparam logic [GAIN_W-1:0] RST_FEEDBACK_GAIN = GAIN_W'(8192);
   localparam logic [GAIN_W-1:0] RST_WET_GAIN      = GAIN_W'(8192);
   localparam logic [GAIN_W-1:0] RST_DRY_GAIN      = GAIN_W'(16384);
   localparam logic [FL_W-1:0]   RST_FADE_LENGTH   = '0;

   localparam logic [CSR_IDX_W-1:0] REG_DELAY_LENGTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FEEDBACK_GAIN = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_WET_GAIN      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_DRY_GAIN      = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_FADE_LENGTH   = CSR_IDX_W'(4);

   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_FB   = 2'd0;
   localparam mul_sel_type MUL_WET  = 2'd1;
   localparam mul_sel_type MUL_DRY  = 2'd2;
   localparam mul_sel_type MUL_FADE = 2'd3;

   typedef struct packed {
      logic        load_in;
      logic        rd_mem;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        write_mem;
      logic        mix_en;
      logic        fade_step;
      logic        div_start;
      logic        div_take;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic fade_active;
      logic div_done;
   } status_type;

   localparam logic signed [PROD_W-1:0] Q_BIAS = PROD_W'((1 << Q_FRAC) - 1);

   // divide by 2^14, truncating toward zero
   function automatic logic signed [PROD_W-1:0] trunc_q14(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] bias;
      bias = v[PROD_W-1] ? Q_BIAS : '0;
      return (v + bias) >>> Q_FRAC;
   endfunction

   function automatic logic signed [MEM_W-1:0] sat_mem(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-MEM_W:0] top;
      top = v[PROD_W-1:MEM_W-1];
      if (top == '0 || top == '1) begin
         return v[MEM_W-1:0];
      end else if (v[PROD_W-1]) begin
         return {1'b1, {(MEM_W-1){1'b0}}};
      end else begin
         return {1'b0, {(MEM_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [PROD_W-1:0] v);
      logic [PROD_W-SAMPLE_W:0] top;
      top = v[PROD_W-1:SAMPLE_W-1];
      if (top == '0 || top == '1) begin
         return v[SAMPLE_W-1:0];
      end else if (v[PROD_W-1]) begin
         return {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/fbecho_div.sv =====
// Restoring divider for the fade-in scale, one quotient bit per cycle.
// Depends on fbecho_pkg and the shared assertion macros.
`default_nettype none
`include "feedback_echo_with_fade_in_core_macros.svh"

module fbecho_div (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic [fbecho_pkg::DIVD_W-1:0]          dividend,
   input  wire logic                                   negate,
   input  wire logic [fbecho_pkg::FL_W-1:0]            divisor,
   output logic                                        done,
   output logic signed [fbecho_pkg::QUO_W-1:0]         quotient
);

   localparam int QUO_W = fbecho_pkg::QUO_W;
   localparam int FL_W  = fbecho_pkg::FL_W;
   localparam int CNT_W = $clog2(QUO_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [FL_W-1:0]  rem_ff, rem_in;
   logic [FL_W-1:0]  dvs_ff, dvs_in;
   logic [QUO_W-1:0] sh_ff, sh_in;
   logic [QUO_W-1:0] q_ff, q_in;
   logic             neg_ff, neg_in;
   logic [FL_W:0]    trial;
   logic [FL_W:0]    diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, sh_ff[QUO_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W - 1);
         rem_in  = dividend[fbecho_pkg::DIVD_W-1:QUO_W];
         sh_in   = dividend[QUO_W-1:0];
         dvs_in  = divisor;
         neg_in  = negate;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[FL_W-1:0] : trial[FL_W-1:0];
         q_in   = {q_ff[QUO_W-2:0], ge};
         sh_in  = {sh_ff[QUO_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);

   // count < length keeps the scaled value inside the positive sample range
   `FBECHO_ASSERT_IMP(a_quotient_range, done_ff, !q_ff[QUO_W-1], "fade quotient overflow")

endmodule

`default_nettype wire

// ===== design/fbecho_ctrl.sv =====
// Sequencer for the feedback echo: steps one item through the datapath.
// Depends on fbecho_pkg and the shared assertion macros.
`default_nettype none
`include "feedback_echo_with_fade_in_core_macros.svh"

module fbecho_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire fbecho_pkg::status_type status,
   output fbecho_pkg::cmd_type         cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_OLD    = 4'd1;
   localparam logic [3:0] S_STORE  = 4'd2;
   localparam logic [3:0] S_RD     = 4'd3;
   localparam logic [3:0] S_WET    = 4'd4;
   localparam logic [3:0] S_DRY    = 4'd5;
   localparam logic [3:0] S_MIX    = 4'd6;
   localparam logic [3:0] S_FMUL   = 4'd7;
   localparam logic [3:0] S_DSTART = 4'd8;
   localparam logic [3:0] S_DWAIT  = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               cmd.rd_mem  = 1'b1;
               state_in    = S_OLD;
            end
         end
         S_OLD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = fbecho_pkg::MUL_FB;
            state_in    = S_STORE;
         end
         S_STORE: begin
            cmd.write_mem = 1'b1;
            state_in      = S_RD;
         end
         S_RD: begin
            cmd.rd_mem = 1'b1;
            state_in   = S_WET;
         end
         S_WET: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = fbecho_pkg::MUL_WET;
            state_in    = S_DRY;
         end
         S_DRY: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = fbecho_pkg::MUL_DRY;
            cmd.acc_load = 1'b1;
            state_in     = S_MIX;
         end
         S_MIX: begin
            cmd.mix_en = 1'b1;
            state_in   = status.fade_active ? S_FMUL : S_OUT;
         end
         S_FMUL: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = fbecho_pkg::MUL_FADE;
            cmd.fade_step = 1'b1;
            state_in      = S_DSTART;
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `FBECHO_ASSERT_IMP(a_no_result_overwrite, cmd.out_load, !rsp_valid_ff || rsp_tready, "result overwritten")
   `FBECHO_ASSERT_NXT(a_accept_starts_item, req_tvalid && req_tready, state_ff == S_OLD, "accept lost")

endmodule

`default_nettype wire

// ===== design/fbecho_dp.sv =====
// Datapath: config registers, delay memory, shared multiplier, mix and fade.
// Depends on fbecho_pkg, fbecho_div and the shared assertion macros.
`default_nettype none
`include "feedback_echo_with_fade_in_core_macros.svh"

module fbecho_dp #(
   parameter int DELAY_DEPTH = fbecho_pkg::DEF_DELAY_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire fbecho_pkg::cmd_type                    cmd,
   output fbecho_pkg::status_type                      status,
   input  wire logic                                   csr_write,
   input  wire logic [fbecho_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fbecho_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic signed [fbecho_pkg::SAMPLE_W-1:0] sample_in,
   input  wire logic                                   last_in,
   output logic signed [fbecho_pkg::SAMPLE_W-1:0]      sample_out,
   output logic                                        last_out
);

   localparam int SAMPLE_W = fbecho_pkg::SAMPLE_W;
   localparam int GAIN_W   = fbecho_pkg::GAIN_W;
   localparam int DL_W     = fbecho_pkg::DL_W;
   localparam int FL_W     = fbecho_pkg::FL_W;
   localparam int MEM_W    = fbecho_pkg::MEM_W;
   localparam int OPA_W    = fbecho_pkg::OPA_W;
   localparam int OPB_W    = fbecho_pkg::OPB_W;
   localparam int PROD_W   = fbecho_pkg::PROD_W;
   localparam int DIVD_W   = fbecho_pkg::DIVD_W;
   localparam int PTR_W    = $clog2(DELAY_DEPTH);
   localparam int FILL_W   = PTR_W + 1;
   localparam int CMP_W    = (DL_W > FILL_W) ? DL_W : FILL_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DELAY_DEPTH);
   localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

   // configuration
   logic [DL_W-1:0]   dl_ff, dl_in;
   logic [GAIN_W-1:0] fb_ff, fb_in;
   logic [GAIN_W-1:0] wet_ff, wet_in;
   logic [GAIN_W-1:0] dry_ff, dry_in;
   logic [FL_W-1:0]   fl_ff, fl_in;

   always_comb begin
      dl_in  = dl_ff;
      fb_in  = fb_ff;
      wet_in = wet_ff;
      dry_in = dry_ff;
      fl_in  = fl_ff;
      if (csr_write) begin
         unique case (csr_index)
            fbecho_pkg::REG_DELAY_LENGTH:  dl_in  = csr_data[DL_W-1:0];
            fbecho_pkg::REG_FEEDBACK_GAIN: fb_in  = csr_data[GAIN_W-1:0];
            fbecho_pkg::REG_WET_GAIN:      wet_in = csr_data[GAIN_W-1:0];
            fbecho_pkg::REG_DRY_GAIN:      dry_in = csr_data[GAIN_W-1:0];
            fbecho_pkg::REG_FADE_LENGTH:   fl_in  = csr_data[FL_W-1:0];
            default: ;
         endcase
      end
   end

   // item registers
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       last_ff;
   logic signed [MEM_W-1:0]    rd_data_ff;
   logic                       rd_ok_ff, rd_ok_in;
   logic signed [MEM_W-1:0]    mem_val;
   logic signed [MEM_W-1:0]    delay_mem_ff [DELAY_DEPTH];
   logic [PTR_W-1:0]           ptr_ff, ptr_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [FL_W-1:0]            fade_cnt_ff, fade_cnt_in;
   logic signed [OPA_W-1:0]    op_a;
   logic signed [OPB_W-1:0]    op_b;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W-1:0]   acc_ff;
   logic signed [PROD_W-1:0]   prod_abs;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic signed [SAMPLE_W-1:0] out_sample_ff;
   logic                       out_last_ff;
   logic signed [MEM_W-1:0]    stored;
   logic [CMP_W-1:0]           dl_ext, ring_len, ptr_next;
   logic                       div_done;
   logic signed [SAMPLE_W-1:0] div_quo;

   assign mem_val = rd_ok_ff ? rd_data_ff : '0;

   always_comb begin
      case (cmd.mul_sel)
         fbecho_pkg::MUL_FB: begin
            op_a = OPA_W'(mem_val);
            op_b = OPB_W'(fb_ff);
         end
         fbecho_pkg::MUL_WET: begin
            op_a = OPA_W'(mem_val);
            op_b = OPB_W'(wet_ff);
         end
         fbecho_pkg::MUL_DRY: begin
            op_a = OPA_W'(sample_ff);
            op_b = OPB_W'(dry_ff);
         end
         default: begin
            op_a = OPA_W'(res_ff);
            op_b = OPB_W'(fade_cnt_ff);
         end
      endcase
      prod_in = op_a * op_b;
   end

   // feedback write value
   assign stored = fbecho_pkg::sat_mem(fbecho_pkg::trunc_q14(prod_ff) + PROD_W'(sample_ff));

   // ring pointer and written extent
   always_comb begin
      dl_ext = CMP_W'(dl_ff);
      if (dl_ff == '0) begin
         ring_len = ONE_C;
      end else if (dl_ext > DEPTH_C) begin
         ring_len = DEPTH_C;
      end else begin
         ring_len = dl_ext;
      end
      ptr_next = CMP_W'(ptr_ff) + ONE_C;
      ptr_in   = ptr_ff;
      fill_in  = fill_ff;
      if (cmd.write_mem) begin
         ptr_in = (ptr_next >= ring_len) ? '0 : ptr_next[PTR_W-1:0];
         if (FILL_W'(ptr_ff) == fill_ff) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
      rd_ok_in = FILL_W'(ptr_ff) < fill_ff;
   end

   always_comb begin
      fade_cnt_in = fade_cnt_ff;
      if (cmd.fade_step) begin
         fade_cnt_in = fade_cnt_ff + FL_W'(1);
      end
      res_in = res_ff;
      if (cmd.mix_en) begin
         res_in = fbecho_pkg::sat_sample(fbecho_pkg::trunc_q14(acc_ff + prod_ff));
      end else if (cmd.div_take) begin
         res_in = div_quo;
      end
      prod_abs = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff       <= fbecho_pkg::RST_DELAY_LENGTH;
         fb_ff       <= fbecho_pkg::RST_FEEDBACK_GAIN;
         wet_ff      <= fbecho_pkg::RST_WET_GAIN;
         dry_ff      <= fbecho_pkg::RST_DRY_GAIN;
         fl_ff       <= fbecho_pkg::RST_FADE_LENGTH;
         ptr_ff      <= '0;
         fill_ff     <= '0;
         fade_cnt_ff <= '0;
      end else begin
         dl_ff       <= dl_in;
         fb_ff       <= fb_in;
         wet_ff      <= wet_in;
         dry_ff      <= dry_in;
         fl_ff       <= fl_in;
         ptr_ff      <= ptr_in;
         fill_ff     <= fill_in;
         fade_cnt_ff <= fade_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sample_ff <= sample_in;
         last_ff   <= last_in;
      end
      if (cmd.rd_mem) begin
         rd_data_ff <= delay_mem_ff[ptr_ff];
         rd_ok_ff   <= rd_ok_in;
      end
      if (cmd.write_mem) begin
         delay_mem_ff[ptr_ff] <= stored;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end
      res_ff <= res_in;
      if (cmd.out_load) begin
         out_sample_ff <= res_ff;
         out_last_ff   <= last_ff;
      end
   end

   fbecho_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_abs[DIVD_W-1:0]),
      .negate   (prod_ff[PROD_W-1]),
      .divisor  (fl_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign status.fade_active = fade_cnt_ff < fl_ff;
   assign status.div_done    = div_done;
   assign sample_out         = out_sample_ff;
   assign last_out           = out_last_ff;

   `FBECHO_ASSERT_IMP(a_ptr_within_fill, 1'b1, FILL_W'(ptr_ff) <= fill_ff, "pointer past written extent")
   `FBECHO_ASSERT_NXT(a_write_extends_fill, cmd.write_mem, fill_ff > FILL_W'($past(ptr_ff)), "written entry not marked")

endmodule

`default_nettype wire

// ===== design/feedback_echo_with_fade_in_core.sv =====
// Top level of the feedback echo with fade-in: sequencer plus datapath.
// Depends on fbecho_pkg, fbecho_ctrl and fbecho_dp.
//
//   channel  direction  tdata / data                     tuser  tlast
//   req_     in         [15:0] sample_in                 -      last_in
//   rsp_     out        [15:0] sample_out                -      last_out
//   csr_     in         index [2:0], data [19:0]         -      -
//
// While the fade-in runs, an item also passes through the 16-step fade
// divider. One item is worked on at a time.
// Reset sets config to defaults and clears pointer, fade count and the
// delay memory's written extent: unwritten entries read as zero with no sweep.
// The result register holds one item; the next item is accepted while it waits.
`default_nettype none

module feedback_echo_with_fade_in_core #(
   parameter int DELAY_DEPTH = fbecho_pkg::DEF_DELAY_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic signed [fbecho_pkg::SAMPLE_W-1:0] req_tdata,  // [15:0] sample_in
   input  wire logic                                   req_tlast,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic signed [fbecho_pkg::SAMPLE_W-1:0]      rsp_tdata,  // [15:0] sample_out
   output logic                                        rsp_tlast,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [fbecho_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fbecho_pkg::CSR_DATA_W-1:0]      csr_data
);

   fbecho_pkg::cmd_type    cmd;
   fbecho_pkg::status_type status;

   assign csr_ready = 1'b1;

   fbecho_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fbecho_dp #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_write  (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .sample_in  (req_tdata),
      .last_in    (req_tlast),
      .sample_out (rsp_tdata),
      .last_out   (rsp_tlast)
   );

endmodule

`default_nettype wire
